// File: hw/rtl/i2cbr_pkg.sv
`default_nettype none
package i2cbr_pkg;

  // sequencer phases
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_SETTLE   = 3'd1;
  localparam logic [2:0] PH_CLK_LOW  = 3'd2;
  localparam logic [2:0] PH_CLK_HIGH = 3'd3;
  localparam logic [2:0] PH_POLL     = 3'd4;
  localparam logic [2:0] PH_START    = 3'd5;
  localparam logic [2:0] PH_STOP     = 3'd6;

  // completion codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SCL_LOW   = 2'd1;
  localparam logic [1:0] ST_STRETCH   = 2'd2;
  localparam logic [1:0] ST_SDA_STUCK = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_SETTLE_TICKS = 3'd0;
  localparam logic [2:0] REG_HALF_PERIOD  = 3'd1;
  localparam logic [2:0] REG_POLL_TICKS   = 3'd2;
  localparam logic [2:0] REG_MAX_PULSES   = 3'd3;
  localparam logic [2:0] REG_MAX_POLLS    = 3'd4;

  localparam logic [23:0] SETTLE_RST = 24'd2500000;
  localparam logic [15:0] HALF_RST   = 16'd10;
  localparam logic [23:0] POLL_RST   = 24'd100000;
  localparam logic [5:0]  PULSES_RST = 6'd20;
  localparam logic [5:0]  POLLS_RST  = 6'd20;

  typedef struct packed {
    logic cmd;
    logic scl_level;
    logic sda_level;
  } in_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       pullup_enable;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic [23:0] settle_ticks;
    logic [15:0] half_period_ticks;
    logic [23:0] poll_ticks;
    logic [5:0]  max_pulses;
    logic [5:0]  max_polls;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [23:0] tick_timer;
    logic [5:0]  pulses_left;
    logic [5:0]  polls_left;
    logic [1:0]  last_status;
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/i2cbr_step.sv
`default_nettype none
module i2cbr_step (
  input  var i2cbr_pkg::state_t st,
  input  var i2cbr_pkg::cfg_t   cfg,
  input  var i2cbr_pkg::in_t    din,
  output i2cbr_pkg::state_t     st_nxt,
  output i2cbr_pkg::out_t       res
);

  logic       decide;
  logic       fin;
  logic [1:0] fin_code;
  logic [5:0] pulses_base;

  always_comb begin
    st_nxt      = st;
    decide      = 1'b0;
    fin         = 1'b0;
    fin_code    = i2cbr_pkg::ST_OK;
    // pulse budget is reloaded when leaving settle
    pulses_base = (st.phase == i2cbr_pkg::PH_SETTLE) ? cfg.max_pulses : st.pulses_left;

    if (st.phase == i2cbr_pkg::PH_IDLE) begin
      if (din.cmd) begin
        st_nxt.phase      = i2cbr_pkg::PH_SETTLE;
        st_nxt.tick_timer = cfg.settle_ticks;
      end
    end else if (st.tick_timer != 24'd0) begin
      st_nxt.tick_timer = st.tick_timer - 24'd1;
    end else begin
      unique case (st.phase)
        i2cbr_pkg::PH_SETTLE: begin
          if (!din.scl_level) begin
            fin      = 1'b1;
            fin_code = i2cbr_pkg::ST_SCL_LOW;
          end else begin
            st_nxt.pulses_left = cfg.max_pulses;
            decide             = 1'b1;
          end
        end
        i2cbr_pkg::PH_CLK_LOW: begin
          st_nxt.phase      = i2cbr_pkg::PH_CLK_HIGH;
          st_nxt.tick_timer = {8'd0, cfg.half_period_ticks};
        end
        i2cbr_pkg::PH_CLK_HIGH: begin
          if (din.scl_level) begin
            decide = 1'b1;
          end else if (cfg.max_polls == 6'd0) begin
            fin      = 1'b1;
            fin_code = i2cbr_pkg::ST_STRETCH;
          end else begin
            st_nxt.polls_left = cfg.max_polls - 6'd1;
            st_nxt.phase      = i2cbr_pkg::PH_POLL;
            st_nxt.tick_timer = cfg.poll_ticks;
          end
        end
        i2cbr_pkg::PH_POLL: begin
          if (din.scl_level) begin
            decide = 1'b1;
          end else if (st.polls_left == 6'd0) begin
            fin      = 1'b1;
            fin_code = i2cbr_pkg::ST_STRETCH;
          end else begin
            st_nxt.polls_left = st.polls_left - 6'd1;
            st_nxt.phase      = i2cbr_pkg::PH_POLL;
            st_nxt.tick_timer = cfg.poll_ticks;
          end
        end
        i2cbr_pkg::PH_START: begin
          st_nxt.phase      = i2cbr_pkg::PH_STOP;
          st_nxt.tick_timer = {8'd0, cfg.half_period_ticks};
        end
        i2cbr_pkg::PH_STOP: begin
          fin      = 1'b1;
          fin_code = i2cbr_pkg::ST_OK;
        end
        default: begin
          st_nxt.phase      = i2cbr_pkg::PH_IDLE;
          st_nxt.tick_timer = 24'd0;
        end
      endcase
    end

    // after an sda sample: another pulse, sda stuck, or start/stop
    if (decide) begin
      if (!din.sda_level) begin
        if (pulses_base != 6'd0) begin
          st_nxt.pulses_left = pulses_base - 6'd1;
          st_nxt.phase       = i2cbr_pkg::PH_CLK_LOW;
          st_nxt.tick_timer  = {8'd0, cfg.half_period_ticks};
        end else begin
          fin      = 1'b1;
          fin_code = i2cbr_pkg::ST_SDA_STUCK;
        end
      end else begin
        st_nxt.phase      = i2cbr_pkg::PH_START;
        st_nxt.tick_timer = {8'd0, cfg.half_period_ticks};
      end
    end

    if (fin) begin
      st_nxt.last_status = fin_code;
      st_nxt.phase       = i2cbr_pkg::PH_IDLE;
      st_nxt.tick_timer  = 24'd0;
    end
  end

  always_comb begin
    res.scl_drive_low = (st_nxt.phase == i2cbr_pkg::PH_CLK_LOW);
    res.sda_drive_low = (st_nxt.phase == i2cbr_pkg::PH_START);
    res.pullup_enable = (st_nxt.phase != i2cbr_pkg::PH_IDLE);
    res.busy_res      = (st_nxt.phase != i2cbr_pkg::PH_IDLE);
    res.done_res      = fin;
    res.status        = st_nxt.last_status;
  end

endmodule
`default_nettype wire

// File: hw/rtl/i2c_bus_recovery_sequencer.sv
// I2C bus recovery sequencer. Each request is one timer tick carrying the sampled SCL and
// SDA levels; each one produces exactly one result showing the line drives, pullup enable,
// busy/done flags and the last completion status after that tick. A request is taken every
// clock cycle unless out_ready stalls a pending result: the next state is one pass of
// combinational logic from the state registers, and the result sits in an output register
// that is refilled in the same cycle it is taken, so throughput is one tick per clock.
// Timing registers (settle, half period, poll interval, pulse and poll limits) are to be
// written through the cfg_ port only while no sequence is running; the block does not
// enforce this. cfg_ready is always high and indexes past the last register are ignored.
`default_nettype none
module i2c_bus_recovery_sequencer (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  var i2cbr_pkg::in_t in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output i2cbr_pkg::out_t    out_data,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [2:0]         cfg_index,
  input  wire  [23:0]        cfg_data
);

  i2cbr_pkg::state_t st_r;
  i2cbr_pkg::state_t st_nxt;
  i2cbr_pkg::cfg_t   cfg_r;
  i2cbr_pkg::out_t   res;
  i2cbr_pkg::out_t   out_r;
  logic              out_valid_r;
  logic              in_acc;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  i2cbr_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .din    (in_data),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks      <= i2cbr_pkg::SETTLE_RST;
      cfg_r.half_period_ticks <= i2cbr_pkg::HALF_RST;
      cfg_r.poll_ticks        <= i2cbr_pkg::POLL_RST;
      cfg_r.max_pulses        <= i2cbr_pkg::PULSES_RST;
      cfg_r.max_polls         <= i2cbr_pkg::POLLS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        i2cbr_pkg::REG_SETTLE_TICKS: cfg_r.settle_ticks      <= cfg_data;
        i2cbr_pkg::REG_HALF_PERIOD:  cfg_r.half_period_ticks <= cfg_data[15:0];
        i2cbr_pkg::REG_POLL_TICKS:   cfg_r.poll_ticks        <= cfg_data;
        i2cbr_pkg::REG_MAX_PULSES:   cfg_r.max_pulses        <= cfg_data[5:0];
        i2cbr_pkg::REG_MAX_POLLS:    cfg_r.max_polls         <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // idle is always entered with the timer cleared
  a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == i2cbr_pkg::PH_IDLE) |-> (st_r.tick_timer == 24'd0))
    else $error("idle phase with running timer");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.done_res) |-> !out_r.busy_res)
    else $error("finish reported while still busy");

  a_one_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.scl_drive_low && out_r.sda_drive_low))
    else $error("both lines driven low");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("pending result lost or changed");

  a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(st_r))
    else $error("state moved without a request");

endmodule
`default_nettype wire

// File: tb/i2c_bus_recovery_sequencer_tb.sv
`default_nettype none
module i2c_bus_recovery_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cbr_pkg::*;

  // an index past the last register, which the block must ignore
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_TICKS = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_SETTLE_TICKS;
  logic [23:0] cfg_data = '0;

  // predictor copy of the registers and the sequencer state
  cfg_t regs = '{SETTLE_RST, HALF_RST, POLL_RST, PULSES_RST, POLLS_RST};
  state_t seq = '{PH_IDLE, 24'd0, 6'd0, 6'd0, ST_OK};
  bit done_now = 1'b0;

  in_t tick_q[$];
  out_t bus_expect_q[$];
  out_t want;

  int errors = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int seq_ends[4] = '{0, 0, 0, 0};
  int idle_left = 0;
  int stall_left = 0;
  int cycles = 0;

  i2c_bus_recovery_sequencer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 39) == 0) begin
      return $urandom_range(10, 30);
    end else if ($urandom_range(0, 3) == 0) begin
      return $urandom_range(1, 3);
    end
    return 0;
  endfunction

  function automatic void end_seq(logic [1:0] code);
    seq.last_status = code;
    seq.phase = PH_IDLE;
    seq.tick_timer = '0;
    done_now = 1'b1;
    seq_ends[code]++;
  endfunction

  function automatic void enter_phase(logic [2:0] ph, logic [23:0] ticks);
    seq.phase = ph;
    seq.tick_timer = ticks;
  endfunction

  // after an sda sample: another pulse, sda stuck, or go on to start/stop
  function automatic void sda_branch(logic sda);
    if (!sda) begin
      if (seq.pulses_left != '0) begin
        seq.pulses_left = seq.pulses_left - 1'b1;
        enter_phase(PH_CLK_LOW, {8'd0, regs.half_period_ticks});
      end else begin
        end_seq(ST_SDA_STUCK);
      end
    end else begin
      enter_phase(PH_START, {8'd0, regs.half_period_ticks});
    end
  endfunction

  function automatic out_t recovery_tick(in_t t);
    out_t o;
    done_now = 1'b0;
    if (seq.phase == PH_IDLE) begin
      if (t.cmd) enter_phase(PH_SETTLE, regs.settle_ticks);
    end else if (seq.tick_timer != '0) begin
      seq.tick_timer = seq.tick_timer - 1'b1;
    end else begin
      case (seq.phase)
        PH_SETTLE: begin
          if (!t.scl_level) begin
            end_seq(ST_SCL_LOW);
          end else begin
            seq.pulses_left = regs.max_pulses;
            sda_branch(t.sda_level);
          end
        end
        PH_CLK_LOW: enter_phase(PH_CLK_HIGH, {8'd0, regs.half_period_ticks});
        PH_CLK_HIGH: begin
          if (t.scl_level) begin
            sda_branch(t.sda_level);
          end else if (regs.max_polls == '0) begin
            end_seq(ST_STRETCH);
          end else begin
            seq.polls_left = regs.max_polls - 1'b1;
            enter_phase(PH_POLL, regs.poll_ticks);
          end
        end
        PH_POLL: begin
          if (t.scl_level) begin
            sda_branch(t.sda_level);
          end else if (seq.polls_left == '0) begin
            end_seq(ST_STRETCH);
          end else begin
            seq.polls_left = seq.polls_left - 1'b1;
            enter_phase(PH_POLL, regs.poll_ticks);
          end
        end
        PH_START: enter_phase(PH_STOP, {8'd0, regs.half_period_ticks});
        PH_STOP: end_seq(ST_OK);
        default: begin
          seq.phase = PH_IDLE;
          seq.tick_timer = '0;
        end
      endcase
    end
    o.scl_drive_low = (seq.phase == PH_CLK_LOW);
    o.sda_drive_low = (seq.phase == PH_START);
    o.pullup_enable = (seq.phase != PH_IDLE);
    o.busy_res = (seq.phase != PH_IDLE);
    o.done_res = done_now;
    o.status = seq.last_status;
    return o;
  endfunction

  function automatic void add_tick(logic cmd, logic scl, logic sda);
    in_t t;
    t.cmd = cmd;
    t.scl_level = scl;
    t.sda_level = sda;
    tick_q.push_back(t);
  endfunction

  // wait until no request is queued, offered or awaiting its result
  task automatic drain();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_valid || bus_expect_q.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_SETTLE_TICKS: regs.settle_ticks = data;
      REG_HALF_PERIOD:  regs.half_period_ticks = data[15:0];
      REG_POLL_TICKS:   regs.poll_ticks = data;
      REG_MAX_PULSES:   regs.max_pulses = data[5:0];
      REG_MAX_POLLS:    regs.max_polls = data[5:0];
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        bus_expect_q.push_back(recovery_tick(in_data));
        idle_left = pick_gap();
      end
      if (!in_valid || in_ready) begin
        if (idle_left != 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= tick_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (bus_expect_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: scl %b sda %b pu %b busy %b done %b st %0d",
                   $time, out_data.scl_drive_low, out_data.sda_drive_low,
                   out_data.pullup_enable, out_data.busy_res, out_data.done_res,
                   out_data.status);
        end else begin
          want = bus_expect_q.pop_front();
          if (out_data.scl_drive_low !== want.scl_drive_low ||
              out_data.sda_drive_low !== want.sda_drive_low ||
              out_data.pullup_enable !== want.pullup_enable ||
              out_data.busy_res !== want.busy_res ||
              out_data.done_res !== want.done_res ||
              out_data.status !== want.status) begin
            errors++;
            $display("%0t: mismatch expected scl %b sda %b pu %b busy %b done %b st %0d",
                     $time, want.scl_drive_low, want.sda_drive_low, want.pullup_enable,
                     want.busy_res, want.done_res, want.status);
            $display("%0t:          actual   scl %b sda %b pu %b busy %b done %b st %0d",
                     $time, out_data.scl_drive_low, out_data.sda_drive_low,
                     out_data.pullup_enable, out_data.busy_res, out_data.done_res,
                     out_data.status);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("i2c_bus_recovery_sequencer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int n_rand;
    int len;
    int scl_low_pct;
    int sda_low_len;
    bit noise;
    n_rand = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: plain ticks only, a request would sit in settle for millions of ticks
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b0, 1'b1, 1'b1);
    drain();
    write_reg(REG_SETTLE_TICKS, 24'd0);
    write_reg(REG_HALF_PERIOD, 24'd0);
    write_reg(REG_POLL_TICKS, 24'd0);
    write_reg(REG_MAX_PULSES, 24'd0);
    write_reg(REG_MAX_POLLS, 24'd0);
    write_reg(REG_UNUSED, 24'hFFFFFF);
    // scl low at the end of settle
    add_tick(1'b1, 1'b1, 1'b1);
    add_tick(1'b0, 1'b0, 1'b1);
    // sda low with no pulses allowed
    add_tick(1'b1, 1'b1, 1'b1);
    add_tick(1'b0, 1'b1, 1'b0);
    // clean bus, start then stop, with a request while busy
    add_tick(1'b1, 1'b1, 1'b1);
    add_tick(1'b0, 1'b1, 1'b1);
    add_tick(1'b1, 1'b1, 1'b1);
    add_tick(1'b0, 1'b1, 1'b1);
    drain();
    // one pulse, then scl held low with no polls allowed
    write_reg(REG_MAX_PULSES, 24'd1);
    add_tick(1'b1, 1'b1, 1'b1);
    add_tick(1'b0, 1'b1, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    drain();
    // stretched clock released on the second poll, then start/stop
    write_reg(REG_MAX_POLLS, 24'd2);
    add_tick(1'b1, 1'b1, 1'b1);
    add_tick(1'b0, 1'b1, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b0, 1'b1, 1'b1);
    add_tick(1'b0, 1'b1, 1'b1);
    add_tick(1'b0, 1'b1, 1'b1);

    while (n_rand < RANDOM_TICKS) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        // small timings so sequences finish; junk in the unused upper bits
        write_reg(REG_SETTLE_TICKS,
                  ($urandom_range(0, 7) == 0) ? 24'd20 : 24'($urandom_range(0, 6)));
        write_reg(REG_HALF_PERIOD,
                  (24'($urandom) & 24'hFF0000) | 24'($urandom_range(0, 3)));
        write_reg(REG_POLL_TICKS, 24'($urandom_range(0, 4)));
        write_reg(REG_MAX_PULSES, (24'($urandom) & 24'hFFFFC0) |
                  (($urandom_range(0, 7) == 0) ? 24'd63 : 24'($urandom_range(0, 5))));
        write_reg(REG_MAX_POLLS, (24'($urandom) & 24'hFFFFC0) |
                  (($urandom_range(0, 7) == 0) ? 24'd63 : 24'($urandom_range(0, 4))));
      end
      noise = ($urandom_range(0, 6) == 0);
      len = $urandom_range(6, 40);
      case ($urandom_range(0, 3))
        0: scl_low_pct = 0;
        1: scl_low_pct = 10;
        2: scl_low_pct = 40;
        default: scl_low_pct = 90;
      endcase
      sda_low_len = $urandom_range(0, 30);
      for (int k = 0; k < len; k++) begin
        if (noise) begin
          add_tick(1'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          // a recovery request, then line levels with sda held low for a while
          add_tick(k == 0 || $urandom_range(0, 19) == 0,
                   $urandom_range(0, 99) >= scl_low_pct,
                   k >= sda_low_len || $urandom_range(0, 9) == 0);
        end
      end
      n_rand += len;
    end

    // widest values last, since a sequence started now outlasts the run
    drain();
    write_reg(REG_SETTLE_TICKS, 24'hFFFFFF);
    write_reg(REG_HALF_PERIOD, 24'hFFFFFF);
    write_reg(REG_POLL_TICKS, 24'hFFFFFF);
    write_reg(REG_MAX_PULSES, 24'hFFFFFF);
    write_reg(REG_MAX_POLLS, 24'hFFFFFF);
    add_tick(1'b1, 1'b1, 1'b1);
    repeat (12) add_tick(1'($urandom), 1'($urandom), 1'($urandom));

    drain();
    repeat (4) @(posedge clk);
    $display("checked %0d ticks across %0d register writes", results_seen, reg_writes);
    $display("recoveries ended: ok %0d, scl low %0d, stretch timeout %0d, sda stuck %0d",
             seq_ends[ST_OK], seq_ends[ST_SCL_LOW], seq_ends[ST_STRETCH],
             seq_ends[ST_SDA_STUCK]);
    if (errors == 0) begin
      $display("i2c_bus_recovery_sequencer_tb: done, clean");
    end else begin
      $display("i2c_bus_recovery_sequencer_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
